// ===== sv/prd_pkg.sv =====
// types, constants and helpers shared by the primary ray direction block
`default_nettype none
package prd_pkg;

  localparam int COORD_W   = 16;
  localparam int VEC_W     = 48;
  localparam int COMP_W    = 16;
  localparam int SCALAR_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int NCOMP     = 3;
  localparam int DIR_W     = 16;

  // offsets and scaled near distance, signed
  localparam int OFF_W  = 2 * (COORD_W + 1);
  localparam int PROD_W = COMP_W + OFF_W;
  localparam int D_W    = PROD_W + 2;
  localparam int MAG_W  = 49;

  // leading one search
  localparam int GRP_W     = 7;
  localparam int NGRP      = (MAG_W + GRP_W - 1) / GRP_W;
  localparam int GRP_IDX_W = $clog2(GRP_W);
  localparam int POS_W     = $clog2(MAG_W);
  localparam int FINE_W    = 3;

  // normalized magnitudes, squared length, root and quotient
  localparam int NORM_W = 30;
  localparam int CRS_W  = NORM_W + (1 << FINE_W) - 1;
  localparam int SQ_W   = 2 * NORM_W + 2;
  localparam int LEN_W  = SQ_W / 2;
  localparam int FRAC_W = 14;
  localparam int Q_W    = FRAC_W + 1;
  localparam int NUM_W  = NORM_W + FRAC_W + 1;

  localparam logic signed [COORD_W:0] HALF_Q16 = (COORD_W + 1)'(1 << (COORD_W - 1));
  localparam logic [Q_W-1:0]          ONE_Q14  = Q_W'(1 << FRAC_W);

  localparam logic [SCALAR_W-1:0] NEAR_RESET   = SCALAR_W'(256);
  localparam logic [SCALAR_W-1:0] WIDTH_RESET  = SCALAR_W'(512);
  localparam logic [SCALAR_W-1:0] HEIGHT_RESET = SCALAR_W'(512);

  // register stages per unit
  localparam int FRONT_STAGES = 4;
  localparam int NORM_STAGES  = 6;
  localparam int SQRT_STAGES  = LEN_W;
  localparam int DIV_STAGES   = Q_W + 2;
  localparam int LATENCY      = FRONT_STAGES + NORM_STAGES + SQRT_STAGES + DIV_STAGES;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORWARD,
    REG_RIGHT,
    REG_UP,
    REG_NEAR,
    REG_WIDTH,
    REG_HEIGHT
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] u_coord;
    logic [COORD_W-1:0] v_coord;
  } in_item_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    logic                    zero_length;
  } result_t;

  typedef struct packed {
    logic [VEC_W-1:0]    forward_vec;
    logic [VEC_W-1:0]    right_vec;
    logic [VEC_W-1:0]    up_vec;
    logic [SCALAR_W-1:0] near_dist;
    logic [SCALAR_W-1:0] view_width;
    logic [SCALAR_W-1:0] view_height;
  } cam_cfg_t;

  typedef struct packed {
    logic [NCOMP-1:0][MAG_W-1:0] mag;
    logic [NCOMP-1:0]            neg;
  } mag_set_t;

  typedef struct packed {
    logic [NCOMP-1:0][NORM_W-1:0] a;
    logic [NCOMP-1:0]             neg;
    logic                         zero;
  } norm_side_t;

  // component of a packed vector, x in the top slot
  function automatic logic signed [COMP_W-1:0] comp_of(logic [VEC_W-1:0] vec, int slot);
    return vec[VEC_W-1-COMP_W*slot -: COMP_W];
  endfunction

endpackage
`default_nettype wire

// ===== sv/primary_ray_direction.sv =====
// top level: configuration registers and the primary ray direction pipeline
//
//   channel   signals                                   beat taken when
//   item      start, busy, item                         start && !busy
//   result    done, result                              done (one cycle, no back-pressure)
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
// a beat can enter every cycle that busy is low; results leave in the order the beats came in
// the pipeline has 4 front, 6 normalize, 31 square root and 17 divide stages
// busy is high only while rst is high; rst clears all valid bits
// nothing stalls: the result strobe cannot be held off
`default_nettype none
module primary_ray_direction (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  prd_pkg::in_item_t             item,
  output logic                          done,
  output prd_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [prd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prd_pkg::VEC_W-1:0]     cfg_data
);
  import prd_pkg::*;

  cam_cfg_t         cfg;
  logic             accept;
  logic             mag_valid;
  mag_set_t         mags;
  logic             sq_valid;
  logic [SQ_W-1:0]  len2;
  norm_side_t       side_n;
  logic             len_valid;
  logic [LEN_W-1:0] len;
  norm_side_t       side_s;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.forward_vec <= '0;
      cfg.right_vec   <= '0;
      cfg.up_vec      <= '0;
      cfg.near_dist   <= NEAR_RESET;
      cfg.view_width  <= WIDTH_RESET;
      cfg.view_height <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FORWARD: cfg.forward_vec <= cfg_data;
        REG_RIGHT:   cfg.right_vec   <= cfg_data;
        REG_UP:      cfg.up_vec      <= cfg_data;
        REG_NEAR:    cfg.near_dist   <= cfg_data[SCALAR_W-1:0];
        REG_WIDTH:   cfg.view_width  <= cfg_data[SCALAR_W-1:0];
        REG_HEIGHT:  cfg.view_height <= cfg_data[SCALAR_W-1:0];
        default: ;
      endcase
    end
  end

  prd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .item      (item),
    .cfg       (cfg),
    .mag_valid (mag_valid),
    .mags      (mags)
  );

  prd_norm u_norm (
    .clk      (clk),
    .rst      (rst),
    .in_valid (mag_valid),
    .mags     (mags),
    .sq_valid (sq_valid),
    .len2     (len2),
    .side     (side_n)
  );

  prd_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .len2      (len2),
    .side      (side_n),
    .out_valid (len_valid),
    .len       (len),
    .side_out  (side_s)
  );

  prd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (len_valid),
    .len      (len),
    .side     (side_s),
    .done     (done),
    .result   (result)
  );

`ifndef SYNTHESIS
  a_beat_out: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("accepted beat produced no result");
  a_beat_in: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result without an accepted beat");
  a_zero_dir: assert property (@(posedge clk) disable iff (rst)
    done && result.zero_length |->
      result.dir_x == 0 && result.dir_y == 0 && result.dir_z == 0)
    else $error("zero length flagged with nonzero direction");
`endif

endmodule
`default_nettype wire

// ===== sv/prd_front.sv =====
// screen offsets, basis products and unnormalized direction magnitudes
`default_nettype none
module prd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  prd_pkg::in_item_t item,
  input  prd_pkg::cam_cfg_t cfg,
  output logic              mag_valid,
  output prd_pkg::mag_set_t mags
);
  import prd_pkg::*;

  logic v1, v2, v3;
  logic signed [COORD_W:0]  du, dv;
  logic signed [OFF_W-1:0]  ox, oy;
  logic signed [OFF_W-1:0]  nf;
  logic signed [PROD_W-1:0] prod_f [NCOMP];
  logic signed [PROD_W-1:0] prod_r [NCOMP];
  logic signed [PROD_W-1:0] prod_p [NCOMP];
  logic signed [D_W-1:0]    d_sum  [NCOMP];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      mag_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      mag_valid <= v3;
    end
  end

  assign nf = signed'(OFF_W'({cfg.near_dist, 16'b0}));

  always_comb begin
    for (int c = 0; c < NCOMP; c++) begin
      d_sum[c] = D_W'(prod_f[c]) + D_W'(prod_r[c]) + D_W'(prod_p[c]);
    end
  end

  always_ff @(posedge clk) begin
    du <= signed'({1'b0, item.u_coord}) - HALF_Q16;
    dv <= HALF_Q16 - signed'({1'b0, item.v_coord});
    ox <= du * signed'({1'b0, cfg.view_width});
    oy <= dv * signed'({1'b0, cfg.view_height});
    for (int c = 0; c < NCOMP; c++) begin
      prod_f[c]   <= comp_of(cfg.forward_vec, c) * nf;
      prod_r[c]   <= comp_of(cfg.right_vec, c) * ox;
      prod_p[c]   <= comp_of(cfg.up_vec, c) * oy;
      mags.neg[c] <= d_sum[c][D_W-1];
      mags.mag[c] <= MAG_W'(d_sum[c][D_W-1] ? -d_sum[c] : d_sum[c]);
    end
  end

endmodule
`default_nettype wire

// ===== sv/prd_norm.sv =====
// leading one search, common shift, squares and squared length
`default_nettype none
module prd_norm (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  prd_pkg::mag_set_t          mags,
  output logic                       sq_valid,
  output logic [prd_pkg::SQ_W-1:0]   len2,
  output prd_pkg::norm_side_t        side
);
  import prd_pkg::*;

  logic [NORM_STAGES-1:0]   vld;
  mag_set_t                 mags_a, mags_b;
  logic [NGRP*GRP_W-1:0]    or_all;
  logic [NGRP-1:0]          grp_nz_c, grp_nz;
  logic [GRP_IDX_W-1:0]     grp_idx_c [NGRP];
  logic [GRP_IDX_W-1:0]     grp_idx   [NGRP];
  logic [POS_W-1:0]         pos_c, pos_b;
  logic                     any_c, zero_b, zero_c;
  logic [POS_W-1:0]         crs_sh;
  logic [CRS_W-1:0]         crs_c [NCOMP];
  logic [CRS_W-1:0]         crs   [NCOMP];
  logic [FINE_W-1:0]        fine;
  logic [NCOMP-1:0]         neg_c;
  norm_side_t               side_d, side_e;
  logic [2*NORM_W-1:0]      sq [NCOMP];
  logic [SQ_W-1:0]          sum_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NORM_STAGES-2:0], in_valid};
    end
  end
  assign sq_valid = vld[NORM_STAGES-1];

  // per group: any bit set, highest set bit
  always_comb begin
    or_all = '0;
    for (int c = 0; c < NCOMP; c++) begin
      or_all[MAG_W-1:0] = or_all[MAG_W-1:0] | mags.mag[c];
    end
    for (int g = 0; g < NGRP; g++) begin
      grp_nz_c[g]  = |or_all[g*GRP_W +: GRP_W];
      grp_idx_c[g] = '0;
      for (int j = 0; j < GRP_W; j++) begin
        if (or_all[g*GRP_W+j]) grp_idx_c[g] = GRP_IDX_W'(j);
      end
    end
  end

  // highest group wins
  always_comb begin
    pos_c = '0;
    any_c = 1'b0;
    for (int g = 0; g < NGRP; g++) begin
      if (grp_nz[g]) begin
        pos_c = POS_W'(g * GRP_W) + POS_W'(grp_idx[g]);
        any_c = 1'b1;
      end
    end
  end

  assign crs_sh = {pos_b[POS_W-1:FINE_W], FINE_W'(0)};

  always_comb begin
    for (int c = 0; c < NCOMP; c++) begin
      crs_c[c] = CRS_W'({mags_b.mag[c], (NORM_W - 1)'(0)} >> crs_sh);
    end
  end

  always_comb begin
    sum_c = '0;
    for (int c = 0; c < NCOMP; c++) begin
      sum_c = sum_c + SQ_W'(sq[c]);
    end
  end

  always_ff @(posedge clk) begin
    mags_a  <= mags;
    grp_nz  <= grp_nz_c;
    grp_idx <= grp_idx_c;

    mags_b <= mags_a;
    pos_b  <= pos_c;
    zero_b <= !any_c;

    crs    <= crs_c;
    fine   <= pos_b[FINE_W-1:0];
    neg_c  <= mags_b.neg;
    zero_c <= zero_b;

    for (int c = 0; c < NCOMP; c++) begin
      side_d.a[c] <= NORM_W'(crs[c] >> fine);
    end
    side_d.neg  <= neg_c;
    side_d.zero <= zero_c;

    for (int c = 0; c < NCOMP; c++) begin
      sq[c] <= side_d.a[c] * side_d.a[c];
    end
    side_e <= side_d;

    len2 <= sum_c;
    side <= side_e;
  end

`ifndef SYNTHESIS
  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    vld[3] && !side_d.zero |->
      side_d.a[0][NORM_W-1] || side_d.a[1][NORM_W-1] || side_d.a[2][NORM_W-1])
    else $error("largest magnitude not normalized");
`endif

endmodule
`default_nettype wire

// ===== sv/prd_sqrt.sv =====
// pipelined integer square root, one root bit per stage
`default_nettype none
module prd_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [prd_pkg::SQ_W-1:0]  len2,
  input  prd_pkg::norm_side_t       side,
  output logic                      out_valid,
  output logic [prd_pkg::LEN_W-1:0] len,
  output prd_pkg::norm_side_t       side_out
);
  import prd_pkg::*;

  logic [LEN_W-1:0] vld;
  logic [SQ_W-1:0]  rem_q  [LEN_W-1];
  logic [LEN_W-1:0] root_q [LEN_W];
  norm_side_t       side_q [LEN_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LEN_W-2:0], in_valid};
    end
  end

  for (genvar i = 0; i < LEN_W; i++) begin : g_stage
    localparam int K = LEN_W - 1 - i;
    logic [SQ_W-1:0]  rem_in;
    logic [LEN_W-1:0] root_in;
    norm_side_t       side_in;
    logic [SQ_W:0]    trial;
    logic             take;

    if (i == 0) begin : g_first
      assign rem_in  = len2;
      assign root_in = '0;
      assign side_in = side;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign trial = ((SQ_W + 1)'(root_in) << (K + 1)) | ((SQ_W + 1)'(1) << (2 * K));
    assign take  = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk) begin
      root_q[i] <= take ? (root_in | (LEN_W'(1) << K)) : root_in;
      side_q[i] <= side_in;
    end

    if (i < LEN_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem_q[i] <= take ? SQ_W'({1'b0, rem_in} - trial) : rem_in;
      end
    end
  end

  assign out_valid = vld[LEN_W-1];
  assign len       = root_q[LEN_W-1];
  assign side_out  = side_q[LEN_W-1];

endmodule
`default_nettype wire

// ===== sv/prd_div.sv =====
// pipelined rounding division by the length, signs and result register
`default_nettype none
module prd_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [prd_pkg::LEN_W-1:0] len,
  input  prd_pkg::norm_side_t       side,
  output logic                      done,
  output prd_pkg::result_t          result
);
  import prd_pkg::*;

  typedef struct packed {
    logic [NCOMP-1:0] neg;
    logic             zero;
  } div_tag_t;

  logic [Q_W:0]                vld;
  logic [NCOMP-1:0][NUM_W-1:0] num;
  logic [LEN_W-1:0]            len_n;
  div_tag_t                    tag_n;
  logic [NCOMP-1:0][NUM_W-1:0] rem_q  [Q_W-1];
  logic [LEN_W-1:0]            len_q  [Q_W-1];
  logic [NCOMP-1:0][Q_W-1:0]   quo    [Q_W];
  div_tag_t                    tag_q  [Q_W];
  logic [Q_W-1:0]              qc     [NCOMP];
  logic signed [DIR_W-1:0]     dir_c  [NCOMP];
  div_tag_t                    tag_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[Q_W-1:0], in_valid};
      done <= vld[Q_W];
    end
  end

  // numerator with half the length for rounding
  always_ff @(posedge clk) begin
    for (int c = 0; c < NCOMP; c++) begin
      num[c] <= NUM_W'({side.a[c], FRAC_W'(0)}) + NUM_W'(len >> 1);
    end
    len_n      <= len;
    tag_n.neg  <= side.neg;
    tag_n.zero <= side.zero;
  end

  for (genvar i = 0; i < Q_W; i++) begin : g_bit
    localparam int B = Q_W - 1 - i;
    logic [NCOMP-1:0][NUM_W-1:0] rem_in;
    logic [LEN_W-1:0]            len_in;
    logic [NCOMP-1:0][Q_W-1:0]   quo_in;
    div_tag_t                    tag_in;
    logic [NUM_W-1:0]            dsh;
    logic [NCOMP-1:0]            take;

    if (i == 0) begin : g_first
      assign rem_in = num;
      assign len_in = len_n;
      assign quo_in = '0;
      assign tag_in = tag_n;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign len_in = len_q[i-1];
      assign quo_in = quo[i-1];
      assign tag_in = tag_q[i-1];
    end

    assign dsh = NUM_W'(len_in) << B;

    always_comb begin
      for (int c = 0; c < NCOMP; c++) begin
        take[c] = rem_in[c] >= dsh;
      end
    end

    always_ff @(posedge clk) begin
      for (int c = 0; c < NCOMP; c++) begin
        quo[i][c] <= quo_in[c] | (take[c] ? (Q_W'(1) << B) : Q_W'(0));
      end
      tag_q[i] <= tag_in;
    end

    if (i < Q_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        for (int c = 0; c < NCOMP; c++) begin
          rem_q[i][c] <= take[c] ? rem_in[c] - dsh : rem_in[c];
        end
        len_q[i] <= len_in;
      end
    end
  end

  assign tag_last = tag_q[Q_W-1];

  always_comb begin
    for (int c = 0; c < NCOMP; c++) begin
      qc[c] = (quo[Q_W-1][c] > ONE_Q14) ? ONE_Q14 : quo[Q_W-1][c];
      if (tag_last.zero) begin
        dir_c[c] = '0;
      end else if (tag_last.neg[c]) begin
        dir_c[c] = -signed'(DIR_W'(qc[c]));
      end else begin
        dir_c[c] = signed'(DIR_W'(qc[c]));
      end
    end
  end

  always_ff @(posedge clk) begin
    result.dir_x       <= dir_c[0];
    result.dir_y       <= dir_c[1];
    result.dir_z       <= dir_c[2];
    result.zero_length <= tag_last.zero;
  end

`ifndef SYNTHESIS
  a_quo_bound: assert property (@(posedge clk) disable iff (rst)
    vld[Q_W] && !tag_last.zero |->
      quo[Q_W-1][0] <= ONE_Q14 && quo[Q_W-1][1] <= ONE_Q14 && quo[Q_W-1][2] <= ONE_Q14)
    else $error("component quotient above one");
`endif

endmodule
`default_nettype wire
